// ----- rtl/implicit_list_heap_allocator_defines.svh -----
// Assertion helpers for the heap allocator.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ILHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ilha_pkg.sv -----
`default_nettype none
package ilha_pkg;
  // heap geometry
  localparam int unsigned HEAP_WORDS  = 8192;
  localparam int unsigned IDX_W       = $clog2(HEAP_WORDS);
  localparam int unsigned ALIGN_BYTES = 16;
  localparam logic [63:0] HEAP_BYTES  = 64'(HEAP_WORDS) * 64'd8;
  localparam logic [63:0] HEAP_CAP    = (HEAP_BYTES > 64'd65536) ? 64'd65536 : HEAP_BYTES;
  localparam logic [63:0] WORD_B      = 64'd8;
  localparam logic [63:0] HDR_B       = 64'd16;
  localparam logic [63:0] TAG_B       = 64'd24;
  localparam logic [63:0] SPLIT_B     = 64'd24 + 64'(ALIGN_BYTES);
  localparam logic [63:0] WALK_CAP    = 64'h1_0000_0000;

  // op codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // register map
  localparam logic REG_HEAP_SIZE = 1'b0;
endpackage
`default_nettype wire

// ----- rtl/ilha_in_if.sv -----
`default_nettype none
interface ilha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] request_size;
  logic [15:0] block_address;
  modport source (output valid, op, request_size, block_address, input ready);
  modport sink   (input valid, op, request_size, block_address, output ready);
endinterface
`default_nettype wire

// ----- rtl/ilha_out_if.sv -----
`default_nettype none
interface ilha_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] payload_address;
  modport source (output valid, status, payload_address, input ready);
  modport sink   (input valid, status, payload_address, output ready);
endinterface
`default_nettype wire

// ----- rtl/implicit_list_heap_allocator.sv -----
`default_nettype none
// First-fit boundary-tag heap allocator over a single-port-read, single-port-write
// 8192 x 64 word memory with a registered read. One beat is handled at a time.
// Allocate walks the blocks, reading the size and allocated words of each, then
// takes a whole free block, splits one, appends at the end, or reports no space;
// a free is rejected by a range check or when the block is not allocated, and
// otherwise merges with a free successor or predecessor. Heap reset and the unused
// op code go straight to posting their result. The next beat is taken while a
// result waits in the output register; the block then holds in its posting cycle
// until that register is emptied. The walk over memory reads sets the allocate
// time, so it grows with heap occupancy.
`include "implicit_list_heap_allocator_defines.svh"
module implicit_list_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ilha_in_if.sink          in_ch,
  ilha_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic        cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_AL_RS  = 19'h00002,
    S_AL_RA  = 19'h00004,
    S_AL_CK  = 19'h00008,
    S_AL_FIT = 19'h00010,
    S_AL_APP = 19'h00020,
    S_FR0    = 19'h00040,
    S_FR1    = 19'h00080,
    S_FR2    = 19'h00100,
    S_FR3    = 19'h00200,
    S_FR4    = 19'h00400,
    S_FR5    = 19'h00800,
    S_FR6    = 19'h01000,
    S_FR7    = 19'h02000,
    S_FR8    = 19'h04000,
    S_BASE   = 19'h08000,
    S_TAIL   = 19'h10000,
    S_WR     = 19'h20000,
    S_FIN    = 19'h40000
  } state_t;

  state_t      state_r, state_nxt;
  logic [16:0] heap_size_r;
  logic [16:0] end_mark_r, end_mark_nxt;
  logic [63:0] cur_r, cur_nxt;
  logic [63:0] size_r, size_nxt;
  logic [63:0] bsz_r, bsz_nxt;
  logic [63:0] rest_r, rest_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] tail_r, tail_nxt;
  logic [63:0] nxt_r, nxt_nxt;
  logic [63:0] psz_r, psz_nxt;
  logic [63:0] phdr_r, phdr_nxt;
  logic [15:0] p_r, p_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [2:0]  wlast_r, wlast_nxt;
  logic        aw_r, aw_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [15:0] pay_r, pay_nxt;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_pay_r;

  // heap memory and its ports
  logic [63:0] heap_mem [ilha_pkg::HEAP_WORDS];
  logic        rd_en, wr_en;
  logic [63:0] rd_addr, wr_addr, wr_data;
  logic [63:0] mem_q;
  logic        oob_q;
  logic [63:0] rdata;

  logic        in_fire, cfg_wr;
  logic [63:0] limit;
  logic [63:0] p64;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign p64       = {48'd0, p_r};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == ilha_pkg::REG_HEAP_SIZE) ? {15'd0, heap_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= 17'h10000;
    end else if (cfg_wr && cfg_paddr == ilha_pkg::REG_HEAP_SIZE) begin
      heap_size_r <= cfg_pwdata[16:0];
    end
  end

  // usable limit: word aligned, capped at the memory size
  always_comb begin
    limit = {47'd0, heap_size_r[16:3], 3'd0};
    if (limit > ilha_pkg::HEAP_CAP) limit = ilha_pkg::HEAP_CAP;
  end

  // memory: out-of-range reads give zero, writes there are dropped
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= heap_mem[rd_addr[ilha_pkg::IDX_W+2:3]];
      oob_q <= (rd_addr >= ilha_pkg::HEAP_BYTES);
    end
    if (wr_en && wr_addr < ilha_pkg::HEAP_BYTES) begin
      heap_mem[wr_addr[ilha_pkg::IDX_W+2:3]] <= wr_data;
    end
  end
  assign rdata = oob_q ? 64'd0 : mem_q;

  // tag write list, indexed by step
  always_comb begin
    unique case (step_r)
      3'd0:    begin wr_addr = cur_r;                       wr_data = size_r; end
      3'd1:    begin wr_addr = cur_r + ilha_pkg::WORD_B;    wr_data = {63'd0, aw_r}; end
      3'd2:    begin wr_addr = base_r;                      wr_data = size_r; end
      3'd3:    begin wr_addr = base_r + ilha_pkg::WORD_B;   wr_data = rest_r; end
      3'd4:    begin wr_addr = base_r + ilha_pkg::HDR_B;    wr_data = 64'd0; end
      3'd5:    begin wr_addr = tail_r;                      wr_data = rest_r; end
      default: begin wr_addr = cur_r;                       wr_data = size_r; end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    end_mark_nxt = end_mark_r;
    cur_nxt      = cur_r;
    size_nxt     = size_r;
    bsz_nxt      = bsz_r;
    rest_nxt     = rest_r;
    base_nxt     = base_r;
    tail_nxt     = tail_r;
    nxt_nxt      = nxt_r;
    psz_nxt      = psz_r;
    phdr_nxt     = phdr_r;
    p_nxt        = p_r;
    step_nxt     = step_r;
    wlast_nxt    = wlast_r;
    aw_nxt       = aw_r;
    st_nxt       = st_r;
    pay_nxt      = pay_r;
    rd_en        = 1'b0;
    rd_addr      = cur_r;
    wr_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt  = ilha_pkg::ST_OK;
          pay_nxt = 16'd0;
          p_nxt   = in_ch.block_address;
          cur_nxt = 64'd0;
          // round the request up to the alignment
          size_nxt = {47'd0, ({1'b0, in_ch.request_size} + 17'(ilha_pkg::ALIGN_BYTES - 1))
                     & ~17'(ilha_pkg::ALIGN_BYTES - 1)};
          priority case (in_ch.op)
            ilha_pkg::OP_ALLOC: state_nxt = S_AL_RS;
            ilha_pkg::OP_FREE:  state_nxt = S_FR0;
            ilha_pkg::OP_RESET: begin
              end_mark_nxt = 17'd0;
              state_nxt    = S_FIN;
            end
            default:            state_nxt = S_FIN;
          endcase
        end
      end
      // first-fit walk: size word, then allocated word
      S_AL_RS: begin
        if (cur_r < {47'd0, end_mark_r}) begin
          rd_en     = 1'b1;
          rd_addr   = cur_r;
          state_nxt = S_AL_RA;
        end else begin
          state_nxt = S_AL_APP;
        end
      end
      S_AL_RA: begin
        bsz_nxt   = rdata;
        rd_en     = 1'b1;
        rd_addr   = cur_r + ilha_pkg::WORD_B;
        state_nxt = S_AL_CK;
      end
      S_AL_CK: begin
        if (rdata == 64'd0 && bsz_r >= size_r) begin
          state_nxt = S_AL_FIT;
        end else begin
          cur_nxt   = (bsz_r >= ilha_pkg::WALK_CAP) ? ilha_pkg::WALK_CAP
                      : cur_r + bsz_r + ilha_pkg::TAG_B;
          state_nxt = S_AL_RS;
        end
      end
      S_AL_FIT: begin
        pay_nxt = cur_r[15:0] + 16'd16;
        aw_nxt  = 1'b1;
        if (bsz_r >= size_r + ilha_pkg::SPLIT_B) begin
          rest_nxt  = bsz_r - size_r - ilha_pkg::TAG_B;
          step_nxt  = 3'd0;
          wlast_nxt = 3'd5;
          state_nxt = S_BASE;
        end else begin
          step_nxt  = 3'd1;
          wlast_nxt = 3'd1;
          state_nxt = S_WR;
        end
      end
      S_AL_APP: begin
        if (cur_r + size_r + ilha_pkg::TAG_B > limit) begin
          st_nxt    = ilha_pkg::ST_NOSPACE;
          state_nxt = S_FIN;
        end else begin
          end_mark_nxt = 17'(cur_r + size_r + ilha_pkg::TAG_B);
          pay_nxt      = cur_r[15:0] + 16'd16;
          aw_nxt       = 1'b1;
          step_nxt     = 3'd0;
          wlast_nxt    = 3'd2;
          state_nxt    = S_BASE;
        end
      end
      // free: range check, then allocated word
      S_FR0: begin
        if (p_r[2:0] != 3'd0 || p_r < 16'd16 || {1'b0, p_r} >= end_mark_r) begin
          st_nxt    = ilha_pkg::ST_BADFREE;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = p64 - ilha_pkg::WORD_B;
          state_nxt = S_FR1;
        end
      end
      S_FR1: begin
        if (rdata == 64'd0) begin
          st_nxt    = ilha_pkg::ST_BADFREE;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = p64 - ilha_pkg::HDR_B;
          state_nxt = S_FR2;
        end
      end
      S_FR2: begin
        size_nxt  = rdata;
        cur_nxt   = p64 - ilha_pkg::HDR_B;
        nxt_nxt   = p64 + rdata + ilha_pkg::WORD_B;
        state_nxt = S_FR3;
      end
      // successor
      S_FR3: begin
        if (nxt_r < {47'd0, end_mark_r}) begin
          rd_en     = 1'b1;
          rd_addr   = nxt_r + ilha_pkg::WORD_B;
          state_nxt = S_FR4;
        end else begin
          state_nxt = S_FR6;
        end
      end
      S_FR4: begin
        if (rdata == 64'd0) begin
          rd_en     = 1'b1;
          rd_addr   = nxt_r;
          state_nxt = S_FR5;
        end else begin
          state_nxt = S_FR6;
        end
      end
      S_FR5: begin
        size_nxt  = size_r + rdata + ilha_pkg::TAG_B;
        state_nxt = S_FR6;
      end
      // predecessor footer
      S_FR6: begin
        if (p_r > 16'd16) begin
          rd_en     = 1'b1;
          rd_addr   = p64 - ilha_pkg::TAG_B;
          state_nxt = S_FR7;
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_FR7: begin
        psz_nxt  = rdata;
        phdr_nxt = p64 - 64'd40 - rdata;
        if (p_r >= 16'd40 && rdata <= p64 - 64'd40) begin
          rd_en     = 1'b1;
          rd_addr   = p64 - 64'd32 - rdata;
          state_nxt = S_FR8;
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_FR8: begin
        if (rdata == 64'd0) begin
          size_nxt = size_r + psz_r + ilha_pkg::TAG_B;
          cur_nxt  = phdr_r;
        end
        state_nxt = S_BASE;
      end
      // tag addresses
      S_BASE: begin
        base_nxt  = cur_r + ilha_pkg::HDR_B + size_r;
        state_nxt = (wlast_r == 3'd5) ? S_TAIL : S_WR;
      end
      S_TAIL: begin
        tail_nxt  = base_r + ilha_pkg::TAG_B + rest_r;
        state_nxt = S_WR;
      end
      S_WR: begin
        wr_en    = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == wlast_r) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // free path sets up its tag writes on entry to the address stage
    if (state_r == S_FR6 && p_r <= 16'd16 || state_r == S_FR7 && state_nxt == S_BASE
        || state_r == S_FR8) begin
      aw_nxt    = 1'b0;
      step_nxt  = 3'd0;
      wlast_nxt = 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      end_mark_r <= 17'd0;
    end else begin
      state_r    <= state_nxt;
      end_mark_r <= end_mark_nxt;
    end
    cur_r   <= cur_nxt;
    size_r  <= size_nxt;
    bsz_r   <= bsz_nxt;
    rest_r  <= rest_nxt;
    base_r  <= base_nxt;
    tail_r  <= tail_nxt;
    nxt_r   <= nxt_nxt;
    psz_r   <= psz_nxt;
    phdr_r  <= phdr_nxt;
    p_r     <= p_nxt;
    step_r  <= step_nxt;
    wlast_r <= wlast_nxt;
    aw_r    <= aw_nxt;
    st_r    <= st_nxt;
    pay_r   <= pay_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_valid_r  <= 1'b1;
      out_status_r <= st_r;
      out_pay_r    <= pay_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.payload_address = out_pay_r;

  // checks
  `ILHA_ASSERT_NXT(a_busy_after_beat, in_fire, !in_ch.ready, "accepted beat did not busy the block")
  `ILHA_ASSERT_IMP(a_end_in_heap, 1'b1, {47'd0, end_mark_r} <= ilha_pkg::HEAP_CAP, "end mark past heap")
  `ILHA_ASSERT_IMP(a_fail_no_addr, out_valid_r && out_status_r != ilha_pkg::ST_OK, out_pay_r == 16'd0, "failed beat carries an address")

endmodule
`default_nettype wire
